/* rtl/core/flpms_pkg.sv */
// Shared constants, codes and beat types for the free-list pool with mark-and-sweep collection.
`default_nettype none
package flpms_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int LINK_W    = IDX_W + 1;
    localparam int COUNT_W   = 7;

    localparam logic [LINK_W-1:0]  LINK_NONE = LINK_W'(POOL_SIZE);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_MARK    = 2'd2,
        ACT_COLLECT = 2'd3
    } action_t;

    typedef struct packed {
        action_t          action;
        logic [IDX_W-1:0] entry_index;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]   given_index;
        logic               ok;
        logic [COUNT_W-1:0] freed_count;
    } rsp_t;

    typedef struct packed {
        logic              mark;
        logic [LINK_W-1:0] link;
    } entry_t;

endpackage
`default_nettype wire

/* rtl/core/free_list_pool_with_mark_sweep_core.sv */
// Top level: pool allocator with a linked free list and mark-and-sweep collection.
`default_nettype none
// The pool holds 64 entries, each keeping its free-list link and its reachable mark in one
// word of a single-port memory with a registered read. A command beat is taken when
// start is high and busy is low, and exactly one response beat follows, marked by done for
// a single cycle; the receiver cannot stall it. Free and mark read the entry and then write
// it back; alloc reads the head entry to take its link as the new head. A new command is
// taken only once the last one is done. An alloc on an empty list answers in the next
// cycle. Collect walks the free list, marking each entry, for up to 64 entries, then
// sweeps the whole pool, reading each entry and writing it back with its mark cleared.
module free_list_pool_with_mark_sweep_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire flpms_pkg::cmd_t cmd,
    output logic               busy,
    output logic               done,
    output flpms_pkg::rsp_t    rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_FREE,
        ST_MARK,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_SWEEP_RD,
        ST_SWEEP_WR
    } state_t;

    state_t state_reg, state_next;

    logic [flpms_pkg::LINK_W-1:0]  head_reg, head_next;
    logic [flpms_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [flpms_pkg::LINK_W-1:0]  walk_reg, walk_next;
    logic [flpms_pkg::LINK_W-1:0]  steps_reg, steps_next;
    logic [flpms_pkg::IDX_W-1:0]   sweep_reg, sweep_next;
    logic [flpms_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [flpms_pkg::POOL_SIZE-1:0] valid_reg, valid_next;
    logic                          done_reg, done_next;
    flpms_pkg::rsp_t               rsp_reg, rsp_next;

    flpms_pkg::entry_t             mem [flpms_pkg::POOL_SIZE];
    flpms_pkg::entry_t             rdata_reg;
    logic                          rvalid_reg, rvalid_next;
    logic [flpms_pkg::IDX_W-1:0]   raddr_reg, raddr_next;

    logic                          mem_re;
    logic [flpms_pkg::IDX_W-1:0]   mem_raddr;
    logic                          mem_we;
    logic [flpms_pkg::IDX_W-1:0]   mem_waddr;
    flpms_pkg::entry_t             mem_wdata;
    flpms_pkg::entry_t             rd_entry;
    logic                          accept;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;
    assign accept = start && !busy;

    // An entry that was never written still holds its reset link to the next index.
    always_comb
    begin
        if (rvalid_reg)
        begin
            rd_entry = rdata_reg;
        end
        else
        begin
            rd_entry.mark = 1'b0;
            rd_entry.link = flpms_pkg::LINK_W'(raddr_reg) + flpms_pkg::LINK_W'(1);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        walk_next   = walk_reg;
        steps_next  = steps_reg;
        sweep_next  = sweep_reg;
        count_next  = count_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        mem_we      = 1'b0;
        mem_waddr   = raddr_reg;
        mem_wdata   = rd_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = cmd.entry_index;
                    unique case (cmd.action)
                        flpms_pkg::ACT_ALLOC:
                        begin
                            if (head_reg < flpms_pkg::LINK_NONE)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg[flpms_pkg::IDX_W-1:0];
                                state_next = ST_ALLOC;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{given_index: '0, ok: 1'b0, freed_count: '0};
                            end
                        end
                        flpms_pkg::ACT_FREE:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = cmd.entry_index;
                            state_next = ST_FREE;
                        end
                        flpms_pkg::ACT_MARK:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = cmd.entry_index;
                            state_next = ST_MARK;
                        end
                        flpms_pkg::ACT_COLLECT:
                        begin
                            walk_next  = head_reg;
                            steps_next = '0;
                            state_next = ST_WALK_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ALLOC:
            begin
                head_next  = rd_entry.link;
                done_next  = 1'b1;
                rsp_next   = '{given_index: head_reg[flpms_pkg::IDX_W-1:0], ok: 1'b1,
                               freed_count: '0};
                state_next = ST_IDLE;
            end
            ST_FREE:
            begin
                mem_we         = 1'b1;
                mem_wdata.mark = rd_entry.mark;
                mem_wdata.link = head_reg;
                head_next      = flpms_pkg::LINK_W'(idx_reg);
                done_next      = 1'b1;
                rsp_next       = '{given_index: '0, ok: 1'b1, freed_count: '0};
                state_next     = ST_IDLE;
            end
            ST_MARK:
            begin
                mem_we         = 1'b1;
                mem_wdata.mark = 1'b1;
                mem_wdata.link = rd_entry.link;
                done_next      = 1'b1;
                rsp_next       = '{given_index: '0, ok: 1'b1, freed_count: '0};
                state_next     = ST_IDLE;
            end
            ST_WALK_RD:
            begin
                if ((walk_reg < flpms_pkg::LINK_NONE) &&
                    (steps_reg < flpms_pkg::LINK_W'(flpms_pkg::POOL_SIZE)))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = walk_reg[flpms_pkg::IDX_W-1:0];
                    state_next = ST_WALK_WR;
                end
                else
                begin
                    sweep_next = '0;
                    count_next = '0;
                    state_next = ST_SWEEP_RD;
                end
            end
            ST_WALK_WR:
            begin
                mem_we         = 1'b1;
                mem_wdata.mark = 1'b1;
                mem_wdata.link = rd_entry.link;
                walk_next      = rd_entry.link;
                steps_next     = steps_reg + flpms_pkg::LINK_W'(1);
                state_next     = ST_WALK_RD;
            end
            ST_SWEEP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = sweep_reg;
                state_next = ST_SWEEP_WR;
            end
            ST_SWEEP_WR:
            begin
                mem_we         = 1'b1;
                mem_wdata.mark = 1'b0;
                if (!rd_entry.mark)
                begin
                    mem_wdata.link = head_reg;
                    head_next      = flpms_pkg::LINK_W'(sweep_reg);
                    if (count_reg != flpms_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + flpms_pkg::COUNT_W'(1);
                    end
                end
                if (sweep_reg == flpms_pkg::IDX_W'(flpms_pkg::POOL_SIZE - 1))
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{given_index: '0, ok: 1'b1, freed_count: count_next};
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + flpms_pkg::IDX_W'(1);
                    state_next = ST_SWEEP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mem_we)
        begin
            valid_next[mem_waddr] = 1'b1;
        end
    end

    assign rvalid_next = mem_re ? valid_reg[mem_raddr] : rvalid_reg;
    assign raddr_next  = mem_re ? mem_raddr : raddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
            walk_reg   <= '0;
            steps_reg  <= '0;
            sweep_reg  <= '0;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            raddr_reg  <= '0;
            idx_reg    <= '0;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            valid_reg  <= valid_next;
            done_reg   <= done_next;
            walk_reg   <= walk_next;
            steps_reg  <= steps_next;
            sweep_reg  <= sweep_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            raddr_reg  <= raddr_next;
            idx_reg    <= idx_next;
            rsp_reg    <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // A response only follows an accepted command or the last cycle of an operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start || busy))
        else $error("response without a command");

    // A command that needs the memory keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !((cmd.action == flpms_pkg::ACT_ALLOC) &&
                     (head_reg == flpms_pkg::LINK_NONE))) |=> busy)
        else $error("command did not occupy the block");

    // The free head is always an entry index or the empty marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= flpms_pkg::LINK_NONE)
        else $error("free head out of range");

    // The sweep cannot have freed more entries than it has visited.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP_WR) |-> (count_reg <= flpms_pkg::COUNT_W'(sweep_reg)))
        else $error("sweep count exceeds visited entries");

endmodule
`default_nettype wire

/* tb/sv/free_list_pool_with_mark_sweep_core_tb.sv */
// Self-checking testbench for the free-list pool core: directed table, then random command traffic.
module free_list_pool_with_mark_sweep_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int TAIL_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 600;
    localparam int N_DIRECTED   = 23;

    typedef struct packed {
        flpms_pkg::action_t          act;
        logic [flpms_pkg::IDX_W-1:0] idx;
        logic [6:0]                  reps;
        logic                        typed;
        flpms_pkg::rsp_t             want;
    } step_row_t;

    localparam step_row_t DIRECTED [N_DIRECTED] = '{
        '{flpms_pkg::ACT_ALLOC,   6'd0,  7'd1,  1'b1, '{6'd0,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_ALLOC,   6'd0,  7'd1,  1'b1, '{6'd1,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_MARK,    6'd0,  7'd1,  1'b1, '{6'd0,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_MARK,    6'd63, 7'd1,  1'b1, '{6'd0,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_FREE,    6'd1,  7'd1,  1'b1, '{6'd0,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_ALLOC,   6'd0,  7'd1,  1'b1, '{6'd1,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_COLLECT, 6'd0,  7'd1,  1'b0, '0},
        '{flpms_pkg::ACT_ALLOC,   6'd0,  7'd63, 1'b0, '0},
        '{flpms_pkg::ACT_ALLOC,   6'd0,  7'd1,  1'b1, '{6'd0,  1'b0, 7'd0}},
        '{flpms_pkg::ACT_ALLOC,   6'd63, 7'd1,  1'b1, '{6'd0,  1'b0, 7'd0}},
        '{flpms_pkg::ACT_COLLECT, 6'd0,  7'd1,  1'b1, '{6'd0,  1'b1, 7'd64}},
        '{flpms_pkg::ACT_ALLOC,   6'd0,  7'd1,  1'b1, '{6'd63, 1'b1, 7'd0}},
        '{flpms_pkg::ACT_FREE,    6'd63, 7'd1,  1'b1, '{6'd0,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_FREE,    6'd63, 7'd1,  1'b1, '{6'd0,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_ALLOC,   6'd0,  7'd1,  1'b0, '0},
        '{flpms_pkg::ACT_ALLOC,   6'd0,  7'd1,  1'b0, '0},
        '{flpms_pkg::ACT_COLLECT, 6'd0,  7'd1,  1'b0, '0},
        '{flpms_pkg::ACT_MARK,    6'd21, 7'd1,  1'b1, '{6'd0,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_FREE,    6'd42, 7'd1,  1'b1, '{6'd0,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_COLLECT, 6'd0,  7'd1,  1'b0, '0},
        '{flpms_pkg::ACT_ALLOC,   6'd0,  7'd3,  1'b0, '0},
        '{flpms_pkg::ACT_FREE,    6'd0,  7'd1,  1'b1, '{6'd0,  1'b1, 7'd0}},
        '{flpms_pkg::ACT_COLLECT, 6'd0,  7'd1,  1'b0, '0}
    };

    logic            clk;
    logic            rst_n;
    logic            start;
    flpms_pkg::cmd_t cmd;
    logic            busy;
    logic            done;
    flpms_pkg::rsp_t rsp;

    logic [flpms_pkg::LINK_W-1:0] link_mem [flpms_pkg::POOL_SIZE];
    logic [flpms_pkg::LINK_W-1:0] head;
    logic                         mark_mem [flpms_pkg::POOL_SIZE];

    flpms_pkg::rsp_t awaited_rsp [$];
    int              held_entries [$];
    int              mismatches;
    int              cycle_count;

    free_list_pool_with_mark_sweep_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic flpms_pkg::rsp_t pool_step(input flpms_pkg::cmd_t c);
        flpms_pkg::rsp_t              r;
        logic [flpms_pkg::LINK_W-1:0] p;
        int                           steps;
        int                           freed;
        r       = '0;
        r.ok    = 1'b1;
        freed   = 0;
        case (c.action)
            flpms_pkg::ACT_ALLOC:
            begin
                if (head < flpms_pkg::LINK_NONE)
                begin
                    r.given_index = head[flpms_pkg::IDX_W-1:0];
                    head          = link_mem[head[flpms_pkg::IDX_W-1:0]];
                end
                else
                begin
                    r.ok = 1'b0;
                end
            end
            flpms_pkg::ACT_FREE:
            begin
                link_mem[c.entry_index] = head;
                head                    = flpms_pkg::LINK_W'(c.entry_index);
            end
            flpms_pkg::ACT_MARK:
            begin
                mark_mem[c.entry_index] = 1'b1;
            end
            default:
            begin
                p     = head;
                steps = 0;
                while (p < flpms_pkg::LINK_NONE && steps < flpms_pkg::POOL_SIZE)
                begin
                    mark_mem[p[flpms_pkg::IDX_W-1:0]] = 1'b1;
                    p = link_mem[p[flpms_pkg::IDX_W-1:0]];
                    steps++;
                end
                for (int i = 0; i < flpms_pkg::POOL_SIZE; i++)
                begin
                    if (mark_mem[i])
                    begin
                        mark_mem[i] = 1'b0;
                    end
                    else
                    begin
                        link_mem[i] = head;
                        head        = flpms_pkg::LINK_W'(i);
                        if (freed < int'(flpms_pkg::COUNT_MAX))
                            freed++;
                    end
                end
                r.freed_count = flpms_pkg::COUNT_W'(freed);
            end
        endcase
        return r;
    endfunction

    task automatic send_cmd(input flpms_pkg::cmd_t c, input logic typed,
                            input flpms_pkg::rsp_t want, input int idle_pct,
                            output flpms_pkg::rsp_t model_rsp);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        model_rsp = pool_step(c);
        awaited_rsp.push_back(typed ? want : model_rsp);
        @(negedge clk);
    endtask

    task automatic drain_all();
        start <= 1'b0;
        @(negedge clk);
        while (awaited_rsp.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin : rsp_check
        flpms_pkg::rsp_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $error("unexpected response beat: given_index %0d ok %0d freed_count %0d",
                       rsp.given_index, rsp.ok, rsp.freed_count);
                mismatches++;
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.given_index !== want.given_index)
                begin
                    $error("given_index: expected %0d, got %0d", want.given_index,
                           rsp.given_index);
                    mismatches++;
                end
                if (rsp.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
                    mismatches++;
                end
                if (rsp.freed_count !== want.freed_count)
                begin
                    $error("freed_count: expected %0d, got %0d", want.freed_count,
                           rsp.freed_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        flpms_pkg::cmd_t              c;
        flpms_pkg::rsp_t              r;
        int                           alloc_pct;
        int                           idle_pct;
        int                           k;
        logic                         was_marked [flpms_pkg::POOL_SIZE];
        int                           kept [$];
        logic [flpms_pkg::LINK_W-1:0] walk_p;
        int                           walk_s;

        mismatches  = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        alloc_pct   = 50;
        for (int i = 0; i < flpms_pkg::POOL_SIZE; i++)
        begin
            link_mem[i] = flpms_pkg::LINK_W'(i + 1);
            mark_mem[i] = 1'b0;
        end
        head = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int row = 0; row < N_DIRECTED; row++)
        begin
            c.action      = DIRECTED[row].act;
            c.entry_index = DIRECTED[row].idx;
            for (int n = 0; n < int'(DIRECTED[row].reps); n++)
                send_cmd(c, DIRECTED[row].typed, DIRECTED[row].want, 11, r);
        end
        drain_all();

        // Rebuild the set of entries held by the client from the current pool state.
        held_entries = {};
        for (int i = 0; i < flpms_pkg::POOL_SIZE; i++)
            held_entries.push_back(i);
        walk_p = head;
        walk_s = 0;
        while (walk_p < flpms_pkg::LINK_NONE && walk_s < flpms_pkg::POOL_SIZE)
        begin
            for (int j = held_entries.size() - 1; j >= 0; j--)
                if (held_entries[j] == int'(walk_p))
                    held_entries.delete(j);
            walk_p = link_mem[walk_p[flpms_pkg::IDX_W-1:0]];
            walk_s++;
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 11 : (phase == 1) ? 57 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 100 == 0)
                begin
                    k         = $urandom_range(2);
                    alloc_pct = (k == 0) ? 25 : (k == 1) ? 50 : 85;
                end
                c.entry_index = flpms_pkg::IDX_W'($urandom);
                if ($urandom_range(99) < alloc_pct)
                begin
                    c.action = flpms_pkg::ACT_ALLOC;
                end
                else
                begin
                    k = $urandom_range(99);
                    if (k < 55)
                    begin
                        c.action = flpms_pkg::ACT_FREE;
                        if (held_entries.size() != 0 && $urandom_range(99) < 85)
                        begin
                            k             = $urandom_range(held_entries.size() - 1);
                            c.entry_index = flpms_pkg::IDX_W'(held_entries[k]);
                            held_entries.delete(k);
                        end
                    end
                    else if (k < 92)
                    begin
                        c.action = flpms_pkg::ACT_MARK;
                        if (held_entries.size() != 0 && $urandom_range(99) < 80)
                            c.entry_index = flpms_pkg::IDX_W'(
                                held_entries[$urandom_range(held_entries.size() - 1)]);
                    end
                    else
                    begin
                        c.action = flpms_pkg::ACT_COLLECT;
                    end
                end
                for (int i = 0; i < flpms_pkg::POOL_SIZE; i++)
                    was_marked[i] = mark_mem[i];
                send_cmd(c, 1'b0, '0, idle_pct, r);
                if (c.action == flpms_pkg::ACT_ALLOC && r.ok)
                begin
                    held_entries.push_back(int'(r.given_index));
                end
                else if (c.action == flpms_pkg::ACT_COLLECT)
                begin
                    kept = {};
                    foreach (held_entries[j])
                        if (was_marked[held_entries[j]])
                            kept.push_back(held_entries[j]);
                    held_entries = kept;
                end
                if ($urandom_range(199) == 0)
                    drain_all();
            end
            drain_all();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && awaited_rsp.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
